[src/rti_pkg.sv]
// ----------------------------------------------------------------------------
// rti_pkg
// Shared types and constants for the ray / triangle intersection pipeline.
// ----------------------------------------------------------------------------
package rti_pkg;

    // coordinate word and fixed point formats
    localparam int COORD_W       = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DIST_W        = 31;
    localparam int NORM_W        = 32;
    localparam int NORM_FRAC     = 30;

    // digit width of the pipelined multipliers
    localparam int MUL_CHUNK = 16;

    // configuration port
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // register indexes
    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] REG_DIR_X    = 3'd3;
    localparam logic [2:0] REG_DIR_Y    = 3'd4;
    localparam logic [2:0] REG_DIR_Z    = 3'd5;

    typedef struct packed {
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] a_z;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] b_z;
        logic signed [COORD_W-1:0] c_x;
        logic signed [COORD_W-1:0] c_y;
        logic signed [COORD_W-1:0] c_z;
    } t_tri_in;

    typedef struct packed {
        logic                     hit;
        logic [DIST_W-1:0]        distance;
        logic signed [NORM_W-1:0] normal_x;
        logic signed [NORM_W-1:0] normal_y;
        logic signed [NORM_W-1:0] normal_z;
    } t_tri_out;

endpackage

[src/ray_triangle_intersection_top.sv]
// ----------------------------------------------------------------------------
// ray_triangle_intersection_top
// Moller-Trumbore ray / triangle test on exact fixed point, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------
//  tri in  | in        | i_in_valid/o_in_ready  | i_in_data  (t_tri_in)
//  result  | out       | o_out_valid/i_out_ready| o_out_data (t_tri_out)
//  config  | in        | psel/penable/pready    | paddr, pwdata, prdata
//
//  One triangle a cycle while the pipe is not held; the depth at default widths
//  is set by the quotient and root bit stages of the normal path (61 + 31 stages).
//  Synchronous active-low reset clears the valid bits and ray registers.
//  The whole pipe holds while the output register is full and not taken;
//  nothing is dropped or repeated across a stall.
// ----------------------------------------------------------------------------
module ray_triangle_intersection_top #(
    parameter int FRAC_BITS = rti_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // triangle input
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  rti_pkg::t_tri_in            i_in_data,
    // result output
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output rti_pkg::t_tri_out           o_out_data,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rti_pkg::APB_AW-1:0]  paddr,
    input  logic [rti_pkg::APB_DW-1:0]  pwdata,
    output logic [rti_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    localparam int C   = rti_pkg::COORD_W;
    localparam int K   = rti_pkg::MUL_CHUNK;
    localparam int NF  = rti_pkg::NORM_FRAC;
    localparam int DB  = rti_pkg::DIST_W;
    localparam int NW  = rti_pkg::NORM_W;
    localparam int WE  = C + 1;
    localparam int WX  = 2 * C + 3;
    localparam int W3  = 3 * C + 6;
    localparam int WL  = 4 * C + 8;
    localparam int WTN = W3 + FRAC_BITS;
    localparam int WS  = W3 + DB;
    localparam int WQN = 2 * NF + 1;
    localparam int WM  = NF + 1;
    localparam int LX  = (WE + K - 1) / K;
    localparam int LN  = (WX + K - 1) / K;
    localparam int LTOT = 1 + LX + 1 + LN + 1 + 1 + WQN + WM + 1;
    localparam int APB_IDX_HI = rti_pkg::APB_AW - 1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [2:0][C-1:0] r_org;
    logic [2:0][C-1:0] r_dir;
    logic              w_wr;

    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org <= '0;
            r_dir <= '0;
        end else if (w_wr) begin
            unique case (paddr[APB_IDX_HI:2])
                rti_pkg::REG_ORIGIN_X: r_org[0] <= pwdata;
                rti_pkg::REG_ORIGIN_Y: r_org[1] <= pwdata;
                rti_pkg::REG_ORIGIN_Z: r_org[2] <= pwdata;
                rti_pkg::REG_DIR_X:    r_dir[0] <= pwdata;
                rti_pkg::REG_DIR_Y:    r_dir[1] <= pwdata;
                rti_pkg::REG_DIR_Z:    r_dir[2] <= pwdata;
                default: ;
            endcase
        end
    end

    // register read-back
    always_comb begin
        unique case (paddr[APB_IDX_HI:2])
            rti_pkg::REG_ORIGIN_X: prdata = r_org[0];
            rti_pkg::REG_ORIGIN_Y: prdata = r_org[1];
            rti_pkg::REG_ORIGIN_Z: prdata = r_org[2];
            rti_pkg::REG_DIR_X:    prdata = r_dir[0];
            rti_pkg::REG_DIR_Y:    prdata = r_dir[1];
            rti_pkg::REG_DIR_Z:    prdata = r_dir[2];
            default:               prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // flow control: global advance, valid bits travel with the data
    // ------------------------------------------------------------------
    logic              w_en;
    logic [LTOT-1:0]   r_vld;

    assign w_en        = ~r_vld[LTOT-1] | i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[LTOT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LTOT-2:0], i_in_valid};
        end
    end

    // ------------------------------------------------------------------
    // stage 1: edges e1 = B - A, e2 = C - A, s = O - A
    // ------------------------------------------------------------------
    logic [2:0][C-1:0]          w_va, w_vb, w_vc;
    logic [2:0][WE-1:0]         w_dv;
    logic [2:0][2:0][WE-1:0]    n_ev;
    logic [2:0][2:0][WE-1:0]    r_ev;

    assign w_va = {i_in_data.a_z, i_in_data.a_y, i_in_data.a_x};
    assign w_vb = {i_in_data.b_z, i_in_data.b_y, i_in_data.b_x};
    assign w_vc = {i_in_data.c_z, i_in_data.c_y, i_in_data.c_x};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_ev[0][i] = WE'($signed(w_vb[i])) - WE'($signed(w_va[i]));
            n_ev[1][i] = WE'($signed(w_vc[i])) - WE'($signed(w_va[i]));
            n_ev[2][i] = WE'($signed(r_org[i])) - WE'($signed(w_va[i]));
            w_dv[i]    = WE'($signed(r_dir[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ev <= n_ev;
        end
    end

    // ------------------------------------------------------------------
    // cross products h = D x e2, q = s x e1, n = e1 x e2
    // ------------------------------------------------------------------
    logic [2:0][2:0][WE-1:0]    w_cu, w_cv;
    logic [2:0][2:0][2*WE-1:0]  w_p0, w_p1;
    logic [2:0][2:0][WX-1:0]    r_cr;

    assign w_cu[0] = w_dv;
    assign w_cv[0] = r_ev[1];
    assign w_cu[1] = r_ev[2];
    assign w_cv[1] = r_ev[0];
    assign w_cu[2] = r_ev[0];
    assign w_cv[2] = r_ev[1];

    genvar gk, gi, gd;
    generate
        for (gk = 0; gk < 3; gk++) begin : g_cross
            for (gi = 0; gi < 3; gi++) begin : g_comp
                localparam int I1 = (gi + 1) % 3;
                localparam int I2 = (gi + 2) % 3;

                rti_mul #(.WA(WE), .WB(WE), .K(K)) u_mul_p (
                    .i_clk (i_clk),
                    .i_en  (w_en),
                    .i_a   ($signed(w_cu[gk][I1])),
                    .i_b   ($signed(w_cv[gk][I2])),
                    .o_p   (w_p0[gk][gi])
                );

                rti_mul #(.WA(WE), .WB(WE), .K(K)) u_mul_n (
                    .i_clk (i_clk),
                    .i_en  (w_en),
                    .i_a   ($signed(w_cu[gk][I2])),
                    .i_b   ($signed(w_cv[gk][I1])),
                    .o_p   (w_p1[gk][gi])
                );

                always_ff @(posedge i_clk) begin
                    if (w_en) begin
                        r_cr[gk][gi] <= WX'($signed(w_p0[gk][gi]))
                                      - WX'($signed(w_p1[gk][gi]));
                    end
                end
            end
        end
    endgenerate

    // edges held back to meet the cross products
    logic [2:0][2:0][WE-1:0] w_evd;

    rti_dly #(.W(9 * WE), .N(LX + 1)) u_dly_ev (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (r_ev),
        .o_q   (w_evd)
    );

    // ------------------------------------------------------------------
    // dot products a = e1.h, u = s.h, v = D.q, t = e2.q and |n|^2
    // ------------------------------------------------------------------
    logic [3:0][2:0][WX-1:0]       w_da;
    logic [3:0][2:0][WE-1:0]       w_db;
    logic [3:0][2:0][WX+WE-1:0]    w_dp;
    logic [3:0][W3-1:0]            r_dot;
    logic [2:0][2*WX-1:0]          w_sq;
    logic [2:0][2*WX-1:0]          r_sq;
    logic [WL-1:0]                 r_len2;

    assign w_da[0] = r_cr[0];
    assign w_da[1] = r_cr[0];
    assign w_da[2] = r_cr[1];
    assign w_da[3] = r_cr[1];
    assign w_db[0] = w_evd[0];
    assign w_db[1] = w_evd[2];
    assign w_db[2] = w_dv;
    assign w_db[3] = w_evd[1];

    generate
        for (gd = 0; gd < 4; gd++) begin : g_dot
            for (gi = 0; gi < 3; gi++) begin : g_term
                rti_mul #(.WA(WX), .WB(WE), .K(K)) u_mul (
                    .i_clk (i_clk),
                    .i_en  (w_en),
                    .i_a   ($signed(w_da[gd][gi])),
                    .i_b   ($signed(w_db[gd][gi])),
                    .o_p   (w_dp[gd][gi])
                );
            end

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_dot[gd] <= W3'($signed(w_dp[gd][0])) + W3'($signed(w_dp[gd][1]))
                               + W3'($signed(w_dp[gd][2]));
                end
            end
        end

        for (gi = 0; gi < 3; gi++) begin : g_sq
            rti_mul #(.WA(WX), .WB(WX), .K(K)) u_mul (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_a   ($signed(r_cr[2][gi])),
                .i_b   ($signed(r_cr[2][gi])),
                .o_p   (w_sq[gi])
            );
        end
    endgenerate

    // squares are never negative
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq   <= w_sq;
            r_len2 <= WL'(w_sq[0]) + WL'(w_sq[1]) + WL'(w_sq[2]);
        end
    end

    // line up dots and normal signs with |n|^2
    logic [3:0][W3-1:0] w_dotd;
    logic [2:0]         w_ns;
    logic [2:0]         w_nsd;

    assign w_ns = {r_cr[2][2][WX-1], r_cr[2][1][WX-1], r_cr[2][0][WX-1]};

    rti_dly #(.W(4 * W3), .N(LN - LX)) u_dly_dot (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (r_dot),
        .o_q   (w_dotd)
    );

    rti_dly #(.W(3), .N(LN + 1)) u_dly_ns (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (w_ns),
        .o_q   (w_nsd)
    );

    // ------------------------------------------------------------------
    // decision: fold the sign of a, test barycentrics and t, saturation
    // ------------------------------------------------------------------
    logic signed [W3-1:0] w_a, w_u, w_v, w_t;
    logic signed [W3-1:0] w_fa, w_fu, w_fv, w_ft;
    logic                 w_neg, w_miss, w_sat;
    logic [WS-1:0]        w_alim, w_tsh;

    logic                 r_hit, r_sat;
    logic [WTN-1:0]       r_tnum;
    logic [W3-1:0]        r_aden;
    logic [WL-1:0]        r_dl2;
    logic [2:0][2*WX-1:0] r_dsq;
    logic [2:0]           r_dns;

    always_comb begin
        w_a    = $signed(w_dotd[0]);
        w_u    = $signed(w_dotd[1]);
        w_v    = $signed(w_dotd[2]);
        w_t    = $signed(w_dotd[3]);
        w_neg  = w_a[W3-1];
        w_fa   = w_neg ? -w_a : w_a;
        w_fu   = w_neg ? -w_u : w_u;
        w_fv   = w_neg ? -w_v : w_v;
        w_ft   = w_neg ? -w_t : w_t;
        w_miss = (w_a == '0) || w_fu[W3-1] || (w_fu > w_fa) || w_fv[W3-1]
              || (((W3+1)'(w_fu) + (W3+1)'(w_fv)) > (W3+1)'(w_fa))
              || w_ft[W3-1] || (w_ft == '0);
        // t >= 2^(31 - FRAC_BITS) pins the distance at full scale
        w_alim = WS'(unsigned'(w_fa)) << DB;
        w_tsh  = WS'(unsigned'(w_ft)) << FRAC_BITS;
        w_sat  = (w_alim <= w_tsh);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hit  <= ~w_miss;
            r_sat  <= w_sat;
            r_tnum <= WTN'(unsigned'(w_ft)) << FRAC_BITS;
            r_aden <= w_fa;
            r_dl2  <= r_len2;
            r_dsq  <= r_sq;
            r_dns  <= w_nsd;
        end
    end

    // ------------------------------------------------------------------
    // distance quotient floor(t * 2^FRAC_BITS / a)
    // ------------------------------------------------------------------
    logic [DB-1:0] w_quo, w_quod;
    logic [1:0]    w_hsd;
    logic [2:0]    w_sgd;

    rti_div #(.WN(WTN), .WD(W3), .WQ(DB)) u_div_t (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_tnum),
        .i_den (r_aden),
        .o_quo (w_quo)
    );

    rti_dly #(.W(DB), .N(WQN + WM - DB)) u_dly_quo (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (w_quo),
        .o_q   (w_quod)
    );

    rti_dly #(.W(2), .N(WQN + WM)) u_dly_hs (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({r_hit, r_sat}),
        .o_q   (w_hsd)
    );

    rti_dly #(.W(3), .N(WQN + WM)) u_dly_sg (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (r_dns),
        .o_q   (w_sgd)
    );

    // ------------------------------------------------------------------
    // unit normal: floor(sqrt(floor(n_i^2 * 2^60 / |n|^2)))
    // ------------------------------------------------------------------
    logic [2:0][WQN-1:0] w_qn;
    logic [2:0][WM-1:0]  w_root;

    generate
        for (gi = 0; gi < 3; gi++) begin : g_norm
            rti_div #(.WN(WL + 2 * NF), .WD(WL), .WQ(WQN)) u_div (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_num ((WL + 2 * NF)'(r_dsq[gi]) << (2 * NF)),
                .i_den (r_dl2),
                .o_quo (w_qn[gi])
            );

            rti_isqrt #(.WR(WM)) u_sqrt (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_rad  ((2 * WM)'(w_qn[gi])),
                .o_root (w_root[gi])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // output register, all zero on a miss
    // ------------------------------------------------------------------
    rti_pkg::t_tri_out        n_out, r_out;
    logic [2:0][NW-1:0]       w_nrm;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_nrm[i] = w_sgd[i] ? (NW'(0) - NW'(w_root[i])) : NW'(w_root[i]);
            if (!w_hsd[1]) begin
                w_nrm[i] = '0;
            end
        end
        n_out.hit      = w_hsd[1];
        n_out.distance = !w_hsd[1] ? '0 : (w_hsd[0] ? '1 : w_quod);
        n_out.normal_x = w_nrm[0];
        n_out.normal_y = w_nrm[1];
        n_out.normal_z = w_nrm[2];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

endmodule

[src/rti_dly.sv]
// ----------------------------------------------------------------------------
// rti_dly
// Delay line with stall enable, keeps side data in step with the datapath.
// ----------------------------------------------------------------------------
module rti_dly #(
    parameter int W = 8,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    generate
        if (N == 0) begin : g_none
            assign o_q = i_d;
        end else begin : g_line
            logic [W-1:0] r_sh [N];

            // shift on every advancing cycle
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sh[0] <= i_d;
                    for (int k = 1; k < N; k++) begin
                        r_sh[k] <= r_sh[k-1];
                    end
                end
            end

            assign o_q = r_sh[N-1];
        end
    endgenerate

endmodule

[src/rti_mul.sv]
// ----------------------------------------------------------------------------
// rti_mul
// Pipelined signed multiplier, one K-bit digit of the second operand a stage.
// ----------------------------------------------------------------------------
module rti_mul #(
    parameter int WA = 33,
    parameter int WB = 33,
    parameter int K  = 16
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [WA-1:0]    i_a,
    input  logic signed [WB-1:0]    i_b,
    output logic signed [WA+WB-1:0] o_p
);

    localparam int NS  = (WB + K - 1) / K;
    localparam int WBE = NS * K;
    localparam int WP  = WA + WBE + 1;

    logic signed [WA-1:0]  r_a   [NS];
    logic signed [WBE-1:0] r_b   [NS];
    logic signed [WP-1:0]  r_acc [NS];

    genvar j;
    generate
        for (j = 0; j < NS; j++) begin : g_stg
            logic signed [WA-1:0]  w_a;
            logic signed [WBE-1:0] w_b;
            logic signed [WP-1:0]  w_acc;
            logic [K:0]            w_dig;
            logic signed [WA+K:0]  w_pp;

            if (j == 0) begin : g_first
                assign w_a   = i_a;
                assign w_b   = WBE'(i_b);
                assign w_acc = '0;
            end else begin : g_next
                assign w_a   = r_a[j-1];
                assign w_b   = r_b[j-1];
                assign w_acc = r_acc[j-1];
            end

            // top digit carries the sign, lower digits are unsigned
            if (j == NS - 1) begin : g_top
                assign w_dig = {w_b[WBE-1], w_b[j*K +: K]};
            end else begin : g_low
                assign w_dig = {1'b0, w_b[j*K +: K]};
            end

            assign w_pp = w_a * $signed(w_dig);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_a[j]   <= w_a;
                    r_b[j]   <= w_b;
                    r_acc[j] <= w_acc + (WP'(w_pp) <<< (j * K));
                end
            end
        end
    endgenerate

    assign o_p = r_acc[NS-1][WA+WB-1:0];

endmodule

[src/rti_div.sv]
// ----------------------------------------------------------------------------
// rti_div
// Pipelined restoring divider, one quotient bit a stage. The high part of the
// numerator above the quotient bits must be below the divisor.
// ----------------------------------------------------------------------------
module rti_div #(
    parameter int WN = 64,
    parameter int WD = 32,
    parameter int WQ = 32
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [WN-1:0] i_num,
    input  logic [WD-1:0] i_den,
    output logic [WQ-1:0] o_quo
);

    logic [WD-1:0] r_rem [WQ];
    logic [WQ-1:0] r_low [WQ];
    logic [WD-1:0] r_den [WQ];
    logic [WQ-1:0] r_quo [WQ];

    genvar k;
    generate
        for (k = 0; k < WQ; k++) begin : g_stg
            logic [WD-1:0] w_rem;
            logic [WQ-1:0] w_low;
            logic [WD-1:0] w_den;
            logic [WQ-1:0] w_quo;
            logic [WD:0]   w_try;
            logic [WD:0]   w_dif;
            logic          w_ge;

            if (k == 0) begin : g_first
                assign w_rem = WD'(i_num[WN-1:WQ]);
                assign w_low = i_num[WQ-1:0];
                assign w_den = i_den;
                assign w_quo = '0;
            end else begin : g_next
                assign w_rem = r_rem[k-1];
                assign w_low = r_low[k-1];
                assign w_den = r_den[k-1];
                assign w_quo = r_quo[k-1];
            end

            // bring down the next numerator bit and trial subtract
            assign w_try = {w_rem, w_low[WQ-1-k]};
            assign w_dif = w_try - {1'b0, w_den};
            assign w_ge  = (w_try >= {1'b0, w_den});

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_ge ? w_dif[WD-1:0] : w_try[WD-1:0];
                    r_low[k] <= w_low;
                    r_den[k] <= w_den;
                    r_quo[k] <= {w_quo[WQ-2:0], w_ge};
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[WQ-1];

endmodule

[src/rti_isqrt.sv]
// ----------------------------------------------------------------------------
// rti_isqrt
// Pipelined integer square root, floor(sqrt(x)), one root bit a stage.
// ----------------------------------------------------------------------------
module rti_isqrt #(
    parameter int WR = 31
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [2*WR-1:0]   i_rad,
    output logic [WR-1:0]     o_root
);

    logic [2*WR-1:0] r_rem  [WR];
    logic [WR-1:0]   r_root [WR];

    genvar k;
    generate
        for (k = 0; k < WR; k++) begin : g_stg
            localparam int B = WR - 1 - k;
            logic [2*WR-1:0] w_rem;
            logic [WR-1:0]   w_root;
            logic [2*WR:0]   w_trial;
            logic [2*WR:0]   w_dif;
            logic            w_ge;

            if (k == 0) begin : g_first
                assign w_rem  = i_rad;
                assign w_root = '0;
            end else begin : g_next
                assign w_rem  = r_rem[k-1];
                assign w_root = r_root[k-1];
            end

            // (m + 2^B)^2 - m^2 = m * 2^(B+1) + 2^(2B)
            assign w_trial = ((2*WR+1)'(w_root) << (B + 1)) | ((2*WR+1)'(1) << (2 * B));
            assign w_dif   = {1'b0, w_rem} - w_trial;
            assign w_ge    = ({1'b0, w_rem} >= w_trial);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k]  <= w_ge ? w_dif[2*WR-1:0] : w_rem;
                    r_root[k] <= w_root | (WR'(w_ge) << B);
                end
            end
        end
    endgenerate

    assign o_root = r_root[WR-1];

endmodule

[verif/ray_triangle_intersection_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_triangle_intersection_checker
// Watches the triangle, result and configuration ports, predicts each result
// with exact wide integer arithmetic and compares it with what comes out.
// ----------------------------------------------------------------------------
module ray_triangle_intersection_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  rti_pkg::t_tri_in            in_data,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  rti_pkg::t_tri_out           out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [rti_pkg::APB_AW-1:0]  paddr,
    input  logic [rti_pkg::APB_DW-1:0]  pwdata,
    output int                          fail_count,
    output int                          pending
);

    // wide enough for len2 * m^2 and |n|^2 << 60
    typedef logic signed [255:0] wide_t;
    typedef struct { wide_t x, y, z; } v3_t;

    localparam int NUM_REGS = 6;

    logic [rti_pkg::COORD_W-1:0] ray_reg [NUM_REGS];
    rti_pkg::t_tri_out           expected_results [$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic v3_t v3_load(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        v3_t r;
        r.x = wide_t'($signed(x));
        r.y = wide_t'($signed(y));
        r.z = wide_t'($signed(z));
        return r;
    endfunction

    function automatic v3_t v3_sub(v3_t a, v3_t b);
        v3_t r;
        r.x = a.x - b.x;
        r.y = a.y - b.y;
        r.z = a.z - b.z;
        return r;
    endfunction

    function automatic v3_t vec_cross(v3_t a, v3_t b);
        v3_t r;
        r.x = a.y * b.z - a.z * b.y;
        r.y = a.z * b.x - a.x * b.z;
        r.z = a.x * b.y - a.y * b.x;
        return r;
    endfunction

    function automatic wide_t v3_dot(v3_t a, v3_t b);
        return a.x * b.x + a.y * b.y + a.z * b.z;
    endfunction

    // ni / sqrt(len2) in Q2.30, truncated toward zero
    function automatic logic [31:0] unit_part(wide_t ni, wide_t len2);
        wide_t mag, rhs, cand;
        logic [31:0] m;
        mag = (ni < 0) ? -ni : ni;
        rhs = (mag * mag) <<< 60;
        m   = '0;
        for (int b = 30; b >= 0; b--) begin
            cand = wide_t'(m | (32'd1 << b));
            if (cand * cand * len2 <= rhs)
                m = m | (32'd1 << b);
        end
        return (ni < 0) ? -m : m;
    endfunction

    // Moller-Trumbore test of one triangle against the configured ray
    function automatic rti_pkg::t_tri_out intersect_tri(rti_pkg::t_tri_in t);
        rti_pkg::t_tri_out res;
        v3_t va, vb, vc, org, dir, e1, e2, s, h, q, n;
        wide_t det, un, vn, tn, num, len2;
        res = '0;
        va  = v3_load(t.a_x, t.a_y, t.a_z);
        vb  = v3_load(t.b_x, t.b_y, t.b_z);
        vc  = v3_load(t.c_x, t.c_y, t.c_z);
        org = v3_load(ray_reg[rti_pkg::REG_ORIGIN_X], ray_reg[rti_pkg::REG_ORIGIN_Y],
                      ray_reg[rti_pkg::REG_ORIGIN_Z]);
        dir = v3_load(ray_reg[rti_pkg::REG_DIR_X], ray_reg[rti_pkg::REG_DIR_Y],
                      ray_reg[rti_pkg::REG_DIR_Z]);
        e1  = v3_sub(vb, va);
        e2  = v3_sub(vc, va);
        s   = v3_sub(org, va);
        h   = vec_cross(dir, e2);
        q   = vec_cross(s, e1);
        det = v3_dot(e1, h);
        un  = v3_dot(s, h);
        vn  = v3_dot(dir, q);
        tn  = v3_dot(e2, q);
        // parallel ray or zero area: no epsilon
        if (det == 0)
            return res;
        if (det < 0) begin
            det = -det;
            un  = -un;
            vn  = -vn;
            tn  = -tn;
        end
        if (un < 0 || un > det || vn < 0 || un + vn > det || tn <= 0)
            return res;
        num = tn <<< rti_pkg::FRAC_BITS_DEF;
        if ((det <<< 31) <= num)
            res.distance = '1;
        else
            res.distance = rti_pkg::DIST_W'(num / det);
        n    = vec_cross(e1, e2);
        len2 = v3_dot(n, n);
        res.hit      = 1'b1;
        res.normal_x = unit_part(n.x, len2);
        res.normal_y = unit_part(n.y, len2);
        res.normal_z = unit_part(n.z, len2);
        return res;
    endfunction

    task automatic report(string field, logic [31:0] want, logic [31:0] got);
        $display("checker: %s expected %h got %h at %0t", field, want, got, $realtime);
        fail_count++;
    endtask

    always @(posedge clk) begin
        rti_pkg::t_tri_out want;
        if (!rst_n) begin
            foreach (ray_reg[i])
                ray_reg[i] <= '0;
        end else begin
            // register write on the access phase; unknown indexes ignored
            if (psel && penable && pwrite && pready && (paddr >> 2) < NUM_REGS)
                ray_reg[paddr >> 2] <= pwdata;
            // result transfer
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    report("unexpected result", 32'd0, {31'd0, out_data.hit});
                end else begin
                    want = expected_results.pop_front();
                    if (want.hit !== out_data.hit)
                        report("hit", 32'(want.hit), 32'(out_data.hit));
                    if (want.distance !== out_data.distance)
                        report("distance", 32'(want.distance), 32'(out_data.distance));
                    if (want.normal_x !== out_data.normal_x)
                        report("normal_x", want.normal_x, out_data.normal_x);
                    if (want.normal_y !== out_data.normal_y)
                        report("normal_y", want.normal_y, out_data.normal_y);
                    if (want.normal_z !== out_data.normal_z)
                        report("normal_z", want.normal_z, out_data.normal_z);
                end
            end
            // triangle transfer
            if (in_valid && in_ready)
                expected_results.push_back(intersect_tri(in_data));
        end
        pending = expected_results.size();
    end

endmodule

[verif/ray_triangle_intersection_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_triangle_intersection_top_tb
// Streams triangles at the intersection pipeline under several ray settings:
// directed edge cases, triangles built around a point on the ray, and noise.
// Both sides idle at random; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
module ray_triangle_intersection_top_tb;

    localparam logic [31:0] ONE        = 32'h0001_0000;
    localparam int          IDLE_LIMIT = 4000;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_ready;
    rti_pkg::t_tri_in            i_in_data = '0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    rti_pkg::t_tri_out           o_out_data;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [rti_pkg::APB_AW-1:0]  paddr = '0;
    logic [rti_pkg::APB_DW-1:0]  pwdata = '0;
    logic [rti_pkg::APB_DW-1:0]  prdata;
    logic                        pready;

    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    logic [31:0] ray_org [3];
    logic [31:0] ray_dir [3];

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    ray_triangle_intersection_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    ray_triangle_intersection_checker u_checker (
        .clk        (i_clk),
        .rst_n      (i_rst_n),
        .in_valid   (i_in_valid),
        .in_ready   (o_in_ready),
        .in_data    (i_in_data),
        .out_valid  (o_out_valid),
        .out_ready  (i_out_ready),
        .out_data   (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // watchdog: cycles with no transfer on any port
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("ray_triangle_intersection_top: mismatch");
            $finish;
        end
    end

    // result sink with random stalls and stall-free stretches
    initial begin
        int  stall;
        bit  burst;
        burst = 1'b0;
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0)
                burst = !burst;
            stall = burst ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
            @(negedge i_clk);
        end
    end

    bit in_burst = 1'b0;

    // one triangle transfer; entered and left at a falling edge
    task automatic send_tri(input rti_pkg::t_tri_in tri_item);
        int gap;
        if ($urandom_range(0, 39) == 0)
            in_burst = !in_burst;
        gap = in_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= tri_item;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [rti_pkg::APB_AW-1:0] addr, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // wait until the pipe is empty and settled
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    task automatic set_ray(input logic [31:0] ox, oy, oz, dx, dy, dz);
        drain();
        apb_write(rti_pkg::APB_AW'(rti_pkg::REG_ORIGIN_X) << 2, ox);
        apb_write(rti_pkg::APB_AW'(rti_pkg::REG_ORIGIN_Y) << 2, oy);
        apb_write(rti_pkg::APB_AW'(rti_pkg::REG_ORIGIN_Z) << 2, oz);
        apb_write(rti_pkg::APB_AW'(rti_pkg::REG_DIR_X) << 2, dx);
        apb_write(rti_pkg::APB_AW'(rti_pkg::REG_DIR_Y) << 2, dy);
        apb_write(rti_pkg::APB_AW'(rti_pkg::REG_DIR_Z) << 2, dz);
        ray_org[0] = ox; ray_org[1] = oy; ray_org[2] = oz;
        ray_dir[0] = dx; ray_dir[1] = dy; ray_dir[2] = dz;
    endtask

    function automatic rti_pkg::t_tri_in mk_tri(input logic [31:0] ax, ay, az, bx, by, bz,
                                                cx, cy, cz);
        rti_pkg::t_tri_in r;
        r.a_x = ax; r.a_y = ay; r.a_z = az;
        r.b_x = bx; r.b_y = by; r.b_z = bz;
        r.c_x = cx; r.c_y = cy; r.c_z = cz;
        return r;
    endfunction

    // full range, small, or an extreme
    function automatic logic [31:0] noise_word();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 3) == 0 ? 32'h8000_0000 :
                            $urandom_range(0, 2) == 0 ? 32'h7fff_ffff :
                            $urandom_range(0, 1) == 0 ? 32'hffff_ffff : 32'h0;
            1:       return $signed($urandom) >>> $urandom_range(8, 24);
            default: return $urandom;
        endcase
    endfunction

    function automatic rti_pkg::t_tri_in noise_tri();
        return mk_tri(noise_word(), noise_word(), noise_word(), noise_word(),
                      noise_word(), noise_word(), noise_word(), noise_word(),
                      noise_word());
    endfunction

    // triangle whose centroid is origin + k * dir; jitter pushes it off centre
    function automatic rti_pkg::t_tri_in centroid_tri(input int k, input bit jitter);
        logic [31:0] p [3];
        logic [31:0] u [3];
        logic [31:0] v [3];
        logic [31:0] c [3];
        int          shu, shv;
        shu = $urandom_range(6, 28);
        shv = $urandom_range(6, 28);
        for (int i = 0; i < 3; i++) begin
            p[i] = ray_org[i] + ray_dir[i] * k;
            u[i] = $signed($urandom) >>> shu;
            v[i] = $signed($urandom) >>> shv;
            c[i] = p[i] - u[i] - v[i];
            if (jitter)
                c[i] = c[i] + ($signed($urandom) >>> $urandom_range(4, 28));
        end
        if ($urandom_range(0, 1) == 0)
            return mk_tri(p[0] + u[0], p[1] + u[1], p[2] + u[2],
                          p[0] + v[0], p[1] + v[1], p[2] + v[2], c[0], c[1], c[2]);
        return mk_tri(p[0] + v[0], p[1] + v[1], p[2] + v[2],
                      p[0] + u[0], p[1] + u[1], p[2] + u[2], c[0], c[1], c[2]);
    endfunction

    task automatic random_tris(input int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 19);
            if (pick < 12)
                send_tri(centroid_tri($urandom_range(0, 44) - 4, 1'b0));
            else if (pick < 15)
                send_tri(centroid_tri($urandom_range(0, 44) - 4, 1'b1));
            else
                send_tri(noise_tri());
        end
    endtask

    initial begin
        foreach (ray_org[i]) begin
            ray_org[i] = '0;
            ray_dir[i] = '0;
        end
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset ray: zero direction, everything misses
        send_tri(mk_tri(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'h0, 32'h0, 32'h0));
        send_tri(mk_tri(-ONE, -ONE, 5 * ONE, ONE, -ONE, 5 * ONE, 0, ONE, 5 * ONE));
        repeat (15) send_tri(noise_tri());

        // unit ray along +z from the origin
        set_ray(0, 0, 0, 0, 0, ONE);
        // plain hit at t = 5, and the same with opposite winding
        send_tri(mk_tri(-ONE, -ONE, 5 * ONE, ONE, -ONE, 5 * ONE, 0, ONE, 5 * ONE));
        send_tri(mk_tri(-ONE, -ONE, 5 * ONE, 0, ONE, 5 * ONE, ONE, -ONE, 5 * ONE));
        // hit exactly on a vertex and on an edge
        send_tri(mk_tri(0, 0, 3 * ONE, 2 * ONE, 0, 3 * ONE, 0, 2 * ONE, 3 * ONE));
        send_tri(mk_tri(-ONE, -ONE, 3 * ONE, ONE, -ONE, 3 * ONE, -ONE, ONE, 3 * ONE));
        // triangle behind the origin and through it
        send_tri(mk_tri(-ONE, -ONE, -5 * ONE, ONE, -ONE, -5 * ONE, 0, ONE, -5 * ONE));
        send_tri(mk_tri(-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0));
        // ray parallel to the plane, zero area triangle
        send_tri(mk_tri(ONE, 0, 0, ONE, ONE, 0, ONE, 0, ONE));
        send_tri(mk_tri(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE));
        // misses just beside the triangle
        send_tri(mk_tri(ONE, ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, ONE, 3 * ONE, 2 * ONE));
        random_tris(140);

        // skewed ray with negative components; unknown register written too
        set_ray(32'h0012_3456, 32'hfff0_0000, 32'h0003_8000,
                32'hfffe_8000, 32'h0000_c000, 32'hffff_2000);
        apb_write(5'd24, 32'hdead_beef);
        random_tris(140);

        // extreme register values
        set_ray(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        random_tris(30);

        // huge direction: tiny distance rounds to zero
        set_ray(0, 0, 0, 0, 0, 32'h7fff_ffff);
        send_tri(mk_tri(-ONE, -ONE, 1, ONE, -ONE, 1, 0, ONE, 1));
        random_tris(20);

        // smallest direction: far distance saturates
        set_ray(0, 0, 0, 0, 0, 1);
        send_tri(mk_tri(-ONE, -ONE, 32'h4000_0000, ONE, -ONE, 32'h4000_0000,
                        0, ONE, 32'h4000_0000));
        send_tri(mk_tri(-ONE, -ONE, 32'h7fff_ffff, ONE, -ONE, 32'h7fff_ffff,
                        0, ONE, 32'h7fff_ffff));
        random_tris(20);

        drain();
        repeat (30) @(negedge i_clk);
        if (fail_count == 0)
            $display("ray_triangle_intersection_top: match");
        else
            $display("ray_triangle_intersection_top: mismatch");
        $finish;
    end

endmodule

[filelist.f]
src/rti_pkg.sv
src/rti_dly.sv
src/rti_mul.sv
src/rti_div.sv
src/rti_isqrt.sv
src/ray_triangle_intersection_top.sv
verif/ray_triangle_intersection_checker.sv
verif/ray_triangle_intersection_top_tb.sv
